// ----- hw/rtl/etm_pkg.sv -----
// shared types, constants and arithmetic helpers for the transform matrix core
package etm_pkg;

	localparam int ANGLE_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int CORDIC_STEPS   = 30;
	// sine/cosine unit plus the two rotation product stages
	localparam int ROT_LAT        = CORDIC_STEPS + 4;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;
	localparam logic signed [63:0] Q30_HALF    = 64'sd536870912;

	typedef struct packed {
		logic               action;
		logic        [15:0] angle_x;
		logic        [15:0] angle_y;
		logic        [15:0] angle_z;
		logic signed [15:0] scale_x;
		logic signed [15:0] scale_y;
		logic signed [15:0] scale_z;
		logic signed [31:0] move_x;
		logic signed [31:0] move_y;
		logic signed [31:0] move_z;
	} item_t;

	typedef struct packed {
		logic signed [31:0] col0_row0;
		logic signed [31:0] col0_row1;
		logic signed [31:0] col0_row2;
		logic signed [31:0] col1_row0;
		logic signed [31:0] col1_row1;
		logic signed [31:0] col1_row2;
		logic signed [31:0] col2_row0;
		logic signed [31:0] col2_row1;
		logic signed [31:0] col2_row2;
		logic signed [31:0] offset_x;
		logic signed [31:0] offset_y;
		logic signed [31:0] offset_z;
	} result_t;

	typedef struct packed {
		logic signed [31:0] c;
		logic signed [31:0] s;
	} trig_t;

	// per-column factor: scale or its reciprocal
	typedef struct packed {
		logic             normal;
		logic [2:0][31:0] f;
	} fac_t;

	typedef struct packed {
		logic             normal;
		logic [2:0][31:0] mv;
	} off_t;

	// atan(2^-i) as a fraction of a full turn times 2^32
	function automatic logic [31:0] atan_at(input int i);
		case (i)
			0:       return 32'h20000000;
			1:       return 32'h12E4051E;
			2:       return 32'h09FB385B;
			3:       return 32'h051111D4;
			4:       return 32'h028B0D43;
			5:       return 32'h0145D7E1;
			6:       return 32'h00A2F61E;
			7:       return 32'h00517C55;
			8:       return 32'h0028BE53;
			9:       return 32'h00145F2F;
			10:      return 32'h000A2F98;
			11:      return 32'h000517CC;
			12:      return 32'h00028BE6;
			13:      return 32'h000145F3;
			14:      return 32'h0000A2FA;
			15:      return 32'h0000517D;
			16:      return 32'h000028BE;
			17:      return 32'h0000145F;
			18:      return 32'h00000A30;
			19:      return 32'h00000518;
			20:      return 32'h0000028C;
			21:      return 32'h00000146;
			22:      return 32'h000000A3;
			23:      return 32'h00000051;
			24:      return 32'h00000029;
			25:      return 32'h00000014;
			26:      return 32'h0000000A;
			27:      return 32'h00000005;
			28:      return 32'h00000003;
			29:      return 32'h00000001;
			default: return 32'h00000000;
		endcase
	endfunction

	// q2.30 product, rounded half up
	function automatic logic signed [31:0] mulq30(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] p;
		p = a * b + Q30_HALF;
		return p[61:30];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'h7FFFFFFF;
		end else if (v < -64'sd2147483648) begin
			return 32'h80000000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

// ----- hw/rtl/etm_cordic.sv -----
// pipelined rotation cordic: one binary angle to cosine and sine in q2.30
module etm_cordic #(
	parameter int ANGLE_BITS = etm_pkg::ANGLE_BITS_DEF
) (
	input  logic            clk,
	input  logic            en,
	input  logic     [15:0] angle,
	output etm_pkg::trig_t  cs
);
	import etm_pkg::*;

	localparam int W = 34;
	localparam logic [31:0] AMASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

	logic [31:0] ph;
	logic [31:0] phf;
	logic        neg;

	logic signed [W-1:0] x_s [CORDIC_STEPS+1];
	logic signed [W-1:0] y_s [CORDIC_STEPS+1];
	logic signed [W-1:0] z_s [CORDIC_STEPS+1];
	logic                neg_s [CORDIC_STEPS+1];

	// second and third quarter: turn by half and negate at the end
	always_comb begin
		ph  = (32'(angle) & AMASK) << (32 - ANGLE_BITS);
		neg = (ph[31:30] == 2'b01) || (ph[31:30] == 2'b10);
		phf = neg ? {~ph[31], ph[30:0]} : ph;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]   <= CORDIC_GAIN;
			y_s[0]   <= '0;
			z_s[0]   <= W'(signed'(phf));
			neg_s[0] <= neg;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [W-1:0] dx;
		logic signed [W-1:0] dy;
		logic signed [W-1:0] da;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign da = W'(signed'({1'b0, atan_at(i)}));

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][W-1]) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - da;
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + da;
				end
				neg_s[i+1] <= neg_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cs.c <= neg_s[CORDIC_STEPS] ? 32'(-x_s[CORDIC_STEPS]) : 32'(x_s[CORDIC_STEPS]);
			cs.s <= neg_s[CORDIC_STEPS] ? 32'(-y_s[CORDIC_STEPS]) : 32'(y_s[CORDIC_STEPS]);
		end
	end

endmodule

// ----- hw/rtl/etm_recip.sv -----
// per-column factor: scale, or its rounded reciprocal from a two-bit-per-stage divider
module etm_recip #(
	parameter int FRAC_BITS = etm_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           en,
	input  etm_pkg::item_t item,
	output etm_pkg::fac_t  fac
);
	import etm_pkg::*;

	localparam int QB = FRAC_BITS + 9;
	localparam int NS = (QB + 1) / 2;
	localparam int NB = 2 * NS;
	localparam int PL = ROT_LAT - (NS + 2);
	localparam logic [63:0] NUM = 64'd1 << (FRAC_BITS + 8);

	logic signed [15:0] sc [3];
	logic        [31:0] fsel [3];
	logic               nrm_s [NS+1];
	fac_t               pd_s [PL+1];

	always_comb begin
		sc[0] = item.scale_x;
		sc[1] = item.scale_y;
		sc[2] = item.scale_z;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nrm_s[0] <= item.action;
			for (int i = 0; i < NS; i++) begin
				nrm_s[i+1] <= nrm_s[i];
			end
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_lane
		logic        [16:0]   rem_s [NS+1];
		logic        [NB-1:0] num_s [NS+1];
		logic        [NB-1:0] q_s   [NS+1];
		logic        [15:0]   a_s   [NS+1];
		logic                 sn_s  [NS+1];
		logic                 sz_s  [NS+1];
		logic signed [15:0]   sc_s  [NS+1];
		logic        [15:0]   a_in;
		logic signed [63:0]   qv;
		logic        [31:0]   rcp;

		assign a_in = sc[l][15] ? (~sc[l] + 16'd1) : sc[l];

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[0] <= '0;
				num_s[0] <= NB'(NUM + 64'(a_in >> 1));
				q_s[0]   <= '0;
				a_s[0]   <= a_in;
				sn_s[0]  <= sc[l][15];
				sz_s[0]  <= (sc[l] == 16'sd0);
				sc_s[0]  <= sc[l];
			end
		end

		for (genvar i = 0; i < NS; i++) begin : g_div
			logic [16:0]   r;
			logic [NB-1:0] nm;
			logic [NB-1:0] qq;

			always_comb begin
				r  = rem_s[i];
				nm = num_s[i];
				qq = q_s[i];
				for (int k = 0; k < 2; k++) begin
					r  = {r[15:0], nm[NB-1]};
					nm = nm << 1;
					if (r >= {1'b0, a_s[i]}) begin
						r  = r - {1'b0, a_s[i]};
						qq = {qq[NB-2:0], 1'b1};
					end else begin
						qq = {qq[NB-2:0], 1'b0};
					end
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i+1] <= r;
					num_s[i+1] <= nm;
					q_s[i+1]   <= qq;
					a_s[i+1]   <= a_s[i];
					sn_s[i+1]  <= sn_s[i];
					sz_s[i+1]  <= sz_s[i];
					sc_s[i+1]  <= sc_s[i];
				end
			end
		end

		// zero scale saturates to the largest positive value
		always_comb begin
			qv  = sn_s[NS] ? -signed'(64'(q_s[NS])) : signed'(64'(q_s[NS]));
			rcp = sz_s[NS] ? 32'h7FFFFFFF : sat32(qv);
		end

		assign fsel[l] = nrm_s[NS] ? rcp : 32'(sc_s[NS]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pd_s[0].normal <= nrm_s[NS];
			for (int l = 0; l < 3; l++) begin
				pd_s[0].f[l] <= fsel[l];
			end
			for (int i = 0; i < PL; i++) begin
				pd_s[i+1] <= pd_s[i];
			end
		end
	end

	assign fac = pd_s[PL];

endmodule

// ----- hw/rtl/etm_matrix.sv -----
// rotation products, column factors and final rounding to the output format
module etm_matrix #(
	parameter int FRAC_BITS = etm_pkg::FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             en,
	input  etm_pkg::trig_t   ty,
	input  etm_pkg::trig_t   tx,
	input  etm_pkg::trig_t   tz,
	input  etm_pkg::fac_t    fac,
	output logic [8:0][31:0] ent
);
	import etm_pkg::*;

	localparam logic signed [63:0] RND_M = 64'sd1 <<< (37 - FRAC_BITS);

	logic signed [31:0] p_s1 [10];
	logic signed [31:0] s2_s1;
	logic signed [31:0] s3_s1;
	logic signed [31:0] r_s2 [9];
	logic signed [63:0] p_s3 [9];
	logic               nrm_s3;
	logic signed [63:0] v [9];

	// y angle gives c1/s1, x angle c2/s2, z angle c3/s3
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= mulq30(ty.c, tz.c);
			p_s1[1] <= mulq30(ty.s, tx.s);
			p_s1[2] <= mulq30(tx.c, tz.s);
			p_s1[3] <= mulq30(ty.c, tx.s);
			p_s1[4] <= mulq30(tz.c, ty.s);
			p_s1[5] <= mulq30(ty.c, tz.s);
			p_s1[6] <= mulq30(tx.c, tz.c);
			p_s1[7] <= mulq30(ty.s, tz.s);
			p_s1[8] <= mulq30(tx.c, ty.s);
			p_s1[9] <= mulq30(ty.c, tx.c);
			s2_s1   <= tx.s;
			s3_s1   <= tz.s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s2[0] <= p_s1[0] + mulq30(p_s1[1], s3_s1);
			r_s2[1] <= p_s1[2];
			r_s2[2] <= mulq30(p_s1[3], s3_s1) - p_s1[4];
			r_s2[3] <= mulq30(p_s1[4], s2_s1) - p_s1[5];
			r_s2[4] <= p_s1[6];
			r_s2[5] <= mulq30(p_s1[0], s2_s1) + p_s1[7];
			r_s2[6] <= p_s1[8];
			r_s2[7] <= -s2_s1;
			r_s2[8] <= p_s1[9];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++) begin
				p_s3[i] <= r_s2[i] * signed'(fac.f[i / 3]);
			end
			nrm_s3 <= fac.normal;
		end
	end

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			if (nrm_s3) begin
				v[i] = (p_s3[i] + Q30_HALF) >>> 30;
			end else begin
				v[i] = (p_s3[i] + RND_M) >>> (38 - FRAC_BITS);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++) begin
				ent[i] <= sat32(v[i]);
			end
		end
	end

endmodule

// ----- hw/rtl/euler_trs_transform_matrix_core.sv -----
// throughput: one item per cycle while item_stall is low; the pipeline advances as one unit
// a two-deep output (result register plus skid) lets one more item enter while a result waits
// item_stall is registered: it rises only when the skid register is holding
// reset clears valid bits and the skid flag; payload registers are not reset
module euler_trs_transform_matrix_core #(
	parameter int ANGLE_BITS = etm_pkg::ANGLE_BITS_DEF,
	parameter int FRAC_BITS  = etm_pkg::FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  etm_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output etm_pkg::result_t result
);
	import etm_pkg::*;

	localparam int PIPE = ROT_LAT + 2;

	logic             en;
	logic             skid_q;
	logic             res_v_q;
	result_t          res_q;
	result_t          skid_d_q;
	logic             vld_s1;
	item_t            item_s1;
	logic             vld_p [PIPE];
	off_t             off_p [PIPE];
	trig_t            tx;
	trig_t            ty;
	trig_t            tz;
	fac_t             fac;
	logic [8:0][31:0] ent;
	result_t          pd;
	logic             incoming;

	assign en         = !skid_q;
	assign item_stall = skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int i = 0; i < PIPE; i++) begin
				vld_p[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s1   <= item_valid;
			vld_p[0] <= vld_s1;
			for (int i = 1; i < PIPE; i++) begin
				vld_p[i] <= vld_p[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1         <= item;
			off_p[0].normal <= item_s1.action;
			off_p[0].mv[0]  <= item_s1.move_x;
			off_p[0].mv[1]  <= item_s1.move_y;
			off_p[0].mv[2]  <= item_s1.move_z;
			for (int i = 1; i < PIPE; i++) begin
				off_p[i] <= off_p[i-1];
			end
		end
	end

	etm_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_y (
		.clk   (clk),
		.en    (en),
		.angle (item_s1.angle_y),
		.cs    (ty)
	);

	etm_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_x (
		.clk   (clk),
		.en    (en),
		.angle (item_s1.angle_x),
		.cs    (tx)
	);

	etm_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_z (
		.clk   (clk),
		.en    (en),
		.angle (item_s1.angle_z),
		.cs    (tz)
	);

	etm_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
		.clk  (clk),
		.en   (en),
		.item (item_s1),
		.fac  (fac)
	);

	etm_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
		.clk (clk),
		.en  (en),
		.ty  (ty),
		.tx  (tx),
		.tz  (tz),
		.fac (fac),
		.ent (ent)
	);

	always_comb begin
		pd.col0_row0 = ent[0];
		pd.col0_row1 = ent[1];
		pd.col0_row2 = ent[2];
		pd.col1_row0 = ent[3];
		pd.col1_row1 = ent[4];
		pd.col1_row2 = ent[5];
		pd.col2_row0 = ent[6];
		pd.col2_row1 = ent[7];
		pd.col2_row2 = ent[8];
		pd.offset_x  = off_p[PIPE-1].normal ? 32'sd0 : off_p[PIPE-1].mv[0];
		pd.offset_y  = off_p[PIPE-1].normal ? 32'sd0 : off_p[PIPE-1].mv[1];
		pd.offset_z  = off_p[PIPE-1].normal ? 32'sd0 : off_p[PIPE-1].mv[2];
	end

	// last stage leaves the pipeline whenever it advances
	assign incoming = vld_p[PIPE-1] && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
			skid_q  <= 1'b0;
		end else if (!res_v_q || !result_stall) begin
			if (skid_q) begin
				res_v_q <= 1'b1;
				skid_q  <= 1'b0;
			end else begin
				res_v_q <= incoming;
			end
		end else if (incoming) begin
			skid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!res_v_q || !result_stall) begin
			res_q <= skid_q ? skid_d_q : pd;
		end else if (incoming) begin
			skid_d_q <= pd;
		end
	end

	assign result_valid = res_v_q;
	assign result       = res_q;

endmodule

// ----- test/euler_trs_transform_matrix_core_tb.sv -----
// testbench for the euler trs transform matrix core: fixed-point predictor, directed and random traffic
`timescale 1ns / 1ps

module euler_trs_transform_matrix_core_tb;
	import etm_pkg::*;

	localparam int LATENCY     = 38;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic ACT_MODEL  = 1'b0;
	localparam logic ACT_NORMAL = 1'b1;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	result_t matrix_q[$];
	int      error_count;
	int      cycle_count;
	int      hold_cycles;
	bit      sink_idle_on;
	bit      src_idle_on;

	longint  turn_tab[30];

	euler_trs_transform_matrix_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	initial begin
		turn_tab = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
			64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
			64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
			64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
			64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
			64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};
	end

	// floor shift, exact for negative values
	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint q30_product(longint a, longint b);
		return floor_shift(a * b + (64'sd1 << 29), 30);
	endfunction

	task automatic trig_of(input logic [15:0] ang, output longint c, output longint s);
		logic [31:0] ph;
		logic        flip;
		longint      x, y, z, dx, dy;
		ph = {ang, 16'h0};
		flip = (ph[31:30] == 2'd1) || (ph[31:30] == 2'd2);
		x = 64'h26DD3B6A;
		y = 64'sd0;
		if (flip) begin
			ph[31] = ~ph[31];
		end
		z = longint'(signed'(ph));
		for (int i = 0; i < 30; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= turn_tab[i];
			end else begin
				x += dx; y -= dy; z += turn_tab[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	function automatic longint scale_reciprocal(longint sc);
		longint a, q;
		if (sc == 0) begin
			return 64'sd2147483647;
		end
		a = sc < 0 ? -sc : sc;
		q = ((64'sd1 << 24) + a / 2) / a;
		return clamp32(sc < 0 ? -q : q);
	endfunction

	task automatic predict_matrix(input item_t it, output result_t res);
		longint c1, s1, c2, s2, c3, s3, v;
		longint rot[9];
		longint fac[3];
		logic [8:0][31:0] ent;
		trig_of(it.angle_y, c1, s1);
		trig_of(it.angle_x, c2, s2);
		trig_of(it.angle_z, c3, s3);
		rot[0] = q30_product(c1, c3) + q30_product(q30_product(s1, s2), s3);
		rot[1] = q30_product(c2, s3);
		rot[2] = q30_product(q30_product(c1, s2), s3) - q30_product(c3, s1);
		rot[3] = q30_product(q30_product(c3, s1), s2) - q30_product(c1, s3);
		rot[4] = q30_product(c2, c3);
		rot[5] = q30_product(q30_product(c1, c3), s2) + q30_product(s1, s3);
		rot[6] = q30_product(c2, s1);
		rot[7] = -s2;
		rot[8] = q30_product(c1, c2);
		fac[0] = longint'(it.scale_x);
		fac[1] = longint'(it.scale_y);
		fac[2] = longint'(it.scale_z);
		for (int j = 0; j < 3; j++) begin
			if (it.action == ACT_NORMAL) begin
				fac[j] = scale_reciprocal(fac[j]);
			end
			for (int k = 0; k < 3; k++) begin
				if (it.action == ACT_NORMAL) begin
					v = floor_shift(rot[j*3+k] * fac[j] + (64'sd1 << 29), 30);
				end else begin
					v = floor_shift(rot[j*3+k] * fac[j] + (64'sd1 << 21), 22);
				end
				ent[8-(j*3+k)] = 32'(clamp32(v));
			end
		end
		{res.col0_row0, res.col0_row1, res.col0_row2, res.col1_row0, res.col1_row1,
			res.col1_row2, res.col2_row0, res.col2_row1, res.col2_row2} = ent;
		if (it.action == ACT_NORMAL) begin
			res.offset_x = '0; res.offset_y = '0; res.offset_z = '0;
		end else begin
			res.offset_x = it.move_x; res.offset_y = it.move_y; res.offset_z = it.move_z;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		error_count++;
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
	endtask

	// result checking at the rising edge
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (matrix_q.size() == 0) begin
				report_mismatch("unexpected transfer", result.col0_row0, 32'h0);
			end else begin
				want = matrix_q.pop_front();
				if (result.col0_row0 !== want.col0_row0) begin
					report_mismatch("col0_row0", result.col0_row0, want.col0_row0);
				end
				if (result.col0_row1 !== want.col0_row1) begin
					report_mismatch("col0_row1", result.col0_row1, want.col0_row1);
				end
				if (result.col0_row2 !== want.col0_row2) begin
					report_mismatch("col0_row2", result.col0_row2, want.col0_row2);
				end
				if (result.col1_row0 !== want.col1_row0) begin
					report_mismatch("col1_row0", result.col1_row0, want.col1_row0);
				end
				if (result.col1_row1 !== want.col1_row1) begin
					report_mismatch("col1_row1", result.col1_row1, want.col1_row1);
				end
				if (result.col1_row2 !== want.col1_row2) begin
					report_mismatch("col1_row2", result.col1_row2, want.col1_row2);
				end
				if (result.col2_row0 !== want.col2_row0) begin
					report_mismatch("col2_row0", result.col2_row0, want.col2_row0);
				end
				if (result.col2_row1 !== want.col2_row1) begin
					report_mismatch("col2_row1", result.col2_row1, want.col2_row1);
				end
				if (result.col2_row2 !== want.col2_row2) begin
					report_mismatch("col2_row2", result.col2_row2, want.col2_row2);
				end
				if (result.offset_x !== want.offset_x) begin
					report_mismatch("offset_x", result.offset_x, want.offset_x);
				end
				if (result.offset_y !== want.offset_y) begin
					report_mismatch("offset_y", result.offset_y, want.offset_y);
				end
				if (result.offset_z !== want.offset_z) begin
					report_mismatch("offset_z", result.offset_z, want.offset_z);
				end
			end
		end
	end

	// receiver stall: random, or held for a long stretch
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= sink_idle_on && ($urandom_range(99) < 27);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// valid stays high after a transfer so that the next item can follow directly
	task automatic send_item(input item_t it);
		result_t want;
		while (src_idle_on && $urandom_range(99) < 27) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		predict_matrix(it, want);
		matrix_q.push_back(want);
		@(negedge clk);
	endtask

	function automatic item_t random_item();
		item_t        it;
		logic [223:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		it = raw[192:0];
		case ($urandom_range(5))
			0: it.scale_x = 16'sh0100;
			1: it.scale_y = 16'(signed'($urandom_range(8)) - 4);
			2: it.scale_z = '0;
			default: ;
		endcase
		if ($urandom_range(3) == 0) begin
			it.angle_x = {3'($urandom_range(7)), 13'h0};
		end
		return it;
	endfunction

	task automatic drain_results();
		item_valid <= 1'b0;
		while (matrix_q.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic test_directed();
		item_t it;
		logic [15:0] angs[6] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2000};
		logic [15:0] scs[6]  = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF, 16'h0100};
		for (int i = 0; i < 12; i++) begin
			it.action  = (i % 2) ? ACT_NORMAL : ACT_MODEL;
			it.angle_x = angs[i % 6];
			it.angle_y = angs[(i + 1) % 6];
			it.angle_z = angs[(i + 3) % 6];
			it.scale_x = scs[i % 6];
			it.scale_y = scs[(i + 2) % 6];
			it.scale_z = scs[(i + 4) % 6];
			it.move_x  = (i % 3 == 0) ? 32'h7FFFFFFF : 32'h80000000;
			it.move_y  = (i % 3 == 1) ? 32'hFFFFFFFF : 32'h00000000;
			it.move_z  = $urandom;
			send_item(it);
		end
		drain_results();
	endtask

	task automatic test_backpressure();
		// receiver holds off while the sender keeps offering
		hold_cycles = 120;
		for (int i = 0; i < 60; i++) begin
			send_item(random_item());
		end
		drain_results();
	endtask

	task automatic test_random(input int count, input bit idle);
		src_idle_on = idle;
		sink_idle_on = idle;
		for (int i = 0; i < count; i++) begin
			send_item(random_item());
		end
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		error_count = 0;
		cycle_count = 0;
		hold_cycles = 0;
		sink_idle_on = 1'b1;
		src_idle_on = 1'b1;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_backpressure();
		test_random(700, 1'b1);
		test_random(300, 1'b0);
		drain_results();
		test_random(380, 1'b1);
		drain_results();
		repeat (LATENCY + 10) @(negedge clk);
		if (error_count == 0 && matrix_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/etm_pkg.sv
hw/rtl/etm_cordic.sv
hw/rtl/etm_recip.sv
hw/rtl/etm_matrix.sv
hw/rtl/euler_trs_transform_matrix_core.sv
test/euler_trs_transform_matrix_core_tb.sv
